// File: hdl/psbl_pkg.sv
// Shared widths, operation codes and word types of the prefix-sum bucket locator.
`default_nettype none

package psbl_pkg;

  localparam int VALUE_W  = 40;  // input value field
  localparam int SUM_W    = 50;  // stored prefix sums and running total
  localparam int OFFSET_W = 40;  // offset_in_bucket field
  localparam int INDEX_W  = 11;  // bucket_index field

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic                found;
    logic [INDEX_W-1:0]  bucket_index;
    logic [OFFSET_W-1:0] offset_in_bucket;
    logic                overflow;
  } out_word_t;

endpackage

`default_nettype wire

// File: hdl/psbl_in_if.sv
// Input channel: valid/ready handshake carrying op and value.
`default_nettype none

interface psbl_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [psbl_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/psbl_out_if.sv
// Result channel: valid/ready handshake carrying one result word.
`default_nettype none

interface psbl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [psbl_pkg::INDEX_W-1:0]  bucket_index;
  logic [psbl_pkg::OFFSET_W-1:0] offset_in_bucket;
  logic                          overflow;

  modport source (output valid, output found, output bucket_index,
                  output offset_in_bucket, output overflow, input ready);
  modport sink   (input valid, input found, input bucket_index,
                  input offset_in_bucket, input overflow, output ready);
endinterface

`default_nettype wire

// File: hdl/psbl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none

module psbl_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data when no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/prefix_sum_bucket_locator_core.sv
// Top level of the prefix-sum bucket locator: sequencer, prefix store and result register.
`default_nettype none

// Every input word is either a load (op 0), which appends a bucket size and stores the
// running prefix sum at the next free entry of a one-port-read, one-port-write RAM, or
// a query (op 1), which finds the bucket holding a one-based global position. Every
// word yields exactly one result word. A load into a full store is dropped and returns
// overflow=1. The walk issues one RAM read per cycle, starts at the bucket left by the
// last successful query and moves forward only. For nondecreasing queries that hit,
// the pointer advances at most once per loaded bucket over the whole run.
// The RAM read port sets the walk rate. A position past the loaded total returns
// found=0 and leaves the pointer in place. Keeping queries in order is the caller's
// job; an out-of-order or zero position stops at the pointed bucket and its offset
// wraps. The block takes one word at a time; a finished result sits in an output
// register, so the next word is accepted while it waits. No clearing pass is needed
// after reset: only entries below the bucket count are ever read.
module prefix_sum_bucket_locator_core #(
  parameter int MAX_BUCKETS = 1024,
  parameter int SIZE_BITS   = 40
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  psbl_in_if.sink     in_ch,
  psbl_out_if.source  out_ch
);

  localparam int ADDR_W = $clog2(MAX_BUCKETS);
  localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
  localparam int USED_W = (SIZE_BITS < psbl_pkg::VALUE_W) ? SIZE_BITS : psbl_pkg::VALUE_W;
  localparam logic [psbl_pkg::VALUE_W-1:0] VAL_MASK =
    (USED_W >= psbl_pkg::VALUE_W) ? '1 :
    psbl_pkg::VALUE_W'((64'd1 << USED_W) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BUCKETS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  state_t                         state_r, state_nxt;
  psbl_pkg::op_t                  op_r, op_nxt;
  logic [psbl_pkg::VALUE_W-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [psbl_pkg::SUM_W-1:0]     total_r, total_nxt;
  logic [CNT_W-1:0]               sp_r, sp_nxt;         // committed search pointer
  logic [psbl_pkg::SUM_W-1:0]     sp_base_r, sp_base_nxt; // prefix sum before sp_r
  logic [CNT_W-1:0]               p_r, p_nxt;           // walking pointer
  logic [psbl_pkg::SUM_W-1:0]     wbase_r, wbase_nxt;   // prefix sum before p_r
  logic                           out_valid_r, out_valid_nxt;
  psbl_pkg::out_word_t            out_word_r, out_word_nxt;

  logic                           slot_free;
  logic                           emit;
  psbl_pkg::out_word_t            res;
  logic [psbl_pkg::SUM_W-1:0]     val_ext;
  logic [psbl_pkg::SUM_W-1:0]     sum_w;
  logic [CNT_W-1:0]               p_inc;
  logic                           hit;

  logic                           wr_en;
  logic                           rd_en;
  logic [ADDR_W-1:0]              rd_addr;
  logic [psbl_pkg::SUM_W-1:0]     rd_data;

  psbl_ram #(
    .WIDTH (psbl_pkg::SUM_W),
    .DEPTH (MAX_BUCKETS)
  ) u_prefix_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (sum_w),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign val_ext   = psbl_pkg::SUM_W'(val_r);
  assign sum_w     = total_r + val_ext;
  assign p_inc     = p_r + CNT_W'(1);
  assign hit       = (rd_data >= val_ext);
  assign slot_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.found            = out_word_r.found;
  assign out_ch.bucket_index     = out_word_r.bucket_index;
  assign out_ch.offset_in_bucket = out_word_r.offset_in_bucket;
  assign out_ch.overflow         = out_word_r.overflow;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    sp_nxt      = sp_r;
    sp_base_nxt = sp_base_r;
    p_nxt       = p_r;
    wbase_nxt   = wbase_r;
    emit        = 1'b0;
    res         = '0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = p_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        // latch the word; keep only the low SIZE_BITS of the value
        if (in_ch.valid) begin
          op_nxt    = psbl_pkg::op_t'(in_ch.op);
          val_nxt   = in_ch.value & VAL_MASK;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (op_r == psbl_pkg::OP_LOAD) begin
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (count_r == CNT_FULL) begin
              // drop the load, flag it
              res.overflow = 1'b1;
            end else begin
              wr_en     = 1'b1;
              total_nxt = sum_w;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end else begin
          p_nxt     = sp_r;
          wbase_nxt = sp_base_r;
          if (sp_r >= count_r) begin
            // nothing loaded at or past the pointer: not found
            if (slot_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            rd_en     = 1'b1;
            rd_addr   = sp_r[ADDR_W-1:0];
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        // rd_data holds the prefix sum at p_r; it stays put while stalled
        if (hit) begin
          if (slot_free) begin
            emit                 = 1'b1;
            res.found            = 1'b1;
            res.bucket_index     = psbl_pkg::INDEX_W'(p_inc);
            res.offset_in_bucket = val_r - wbase_r[psbl_pkg::OFFSET_W-1:0];
            sp_nxt               = p_r;
            sp_base_nxt          = wbase_r;
            state_nxt            = S_IDLE;
          end
        end else if (p_inc >= count_r) begin
          // ran past the total: report not found, pointer stays
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          // advance one bucket, probe the next entry
          rd_en     = 1'b1;
          rd_addr   = p_inc[ADDR_W-1:0];
          p_nxt     = p_inc;
          wbase_nxt = rd_data;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
      out_word_nxt  = out_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      sp_r        <= '0;
      sp_base_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      sp_r        <= sp_nxt;
      sp_base_r   <= sp_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    p_r        <= p_nxt;
    wbase_r    <= wbase_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire
